[rtl/core/tscb_pkg.sv]
package tscb_pkg;

  // Store geometry; both maxima are powers of two so a cell address is {row, col}.
  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 64;
  localparam int TAB_STOP    = 8;
  localparam int DEPTH       = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int NC_W        = COL_W + 1;
  localparam int NR_W        = ROW_W + 1;
  localparam int CHAR_W      = 16;
  localparam int REP_W       = 4;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  // Field widths of the ports
  localparam int OP_FW    = 2;
  localparam int RCOL_FW  = 7;
  localparam int RROW_FW  = 6;
  localparam int COLS_FW  = 8;
  localparam int ROWS_FW  = 7;

  // Config register indexes
  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  localparam logic [CHAR_W-1:0] CHR_SPACE = 16'h0020;
  localparam logic [CHAR_W-1:0] CHR_BS    = 16'h0008;
  localparam logic [CHAR_W-1:0] CHR_TAB   = 16'h0009;
  localparam logic [CHAR_W-1:0] CHR_LF    = 16'h000A;
  localparam logic [CHAR_W-1:0] CHR_CR    = 16'h000D;
  localparam logic [CHAR_W-1:0] CHR_ESC   = 16'h001B;

  typedef enum logic [1:0] {
    OP_KEY   = 2'd0,
    OP_CHAR  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    KEY_HOME   = 4'd0,
    KEY_END    = 4'd1,
    KEY_PGUP   = 4'd2,
    KEY_PGDN   = 4'd3,
    KEY_LEFT   = 4'd4,
    KEY_RIGHT  = 4'd5,
    KEY_UP     = 4'd6,
    KEY_DOWN   = 4'd7,
    KEY_DELETE = 4'd8,
    KEY_NONE   = 4'd9
  } key_e;

  typedef enum logic [2:0] {
    CH_BS,
    CH_TAB,
    CH_LF,
    CH_CR,
    CH_ESC,
    CH_PUT
  } chr_e;

  typedef struct packed {
    op_e               kind;
    key_e              key;
    chr_e              chr;
    logic [CHAR_W-1:0] code;
    logic [REP_W-1:0]  rep;
    logic [COL_W-1:0]  rcol;
    logic [ROW_W-1:0]  rrow;
  } cmd_t;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [COL_W-1:0] col,
                                                  logic [ROW_W-1:0] row);
    return ADDR_W'(row) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(col);
  endfunction

  function automatic logic on_tab_stop(logic [COL_W-1:0] col);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < MAX_COLUMNS; k += TAB_STOP) begin
      if (int'(col) == k) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

[rtl/core/tscb_ram.sv]
module tscb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/tscb_front.sv]
module tscb_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tscb_pkg::OP_FW-1:0]   op_i,
  input  logic [tscb_pkg::CHAR_W-1:0]  code_i,
  input  logic [tscb_pkg::REP_W-1:0]   repeat_req_i,
  input  logic [tscb_pkg::RCOL_FW-1:0] read_column_i,
  input  logic [tscb_pkg::RROW_FW-1:0] read_row_i,
  output logic                         q_valid_o,
  output tscb_pkg::cmd_t               q_cmd_o,
  input  logic                         q_pop_i
);
  import tscb_pkg::*;

  cmd_t              ent_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  cmd_t              cmd;
  logic              push, pop;

  // classify the incoming word
  always_comb begin
    cmd.kind = op_e'(op_i);
    cmd.code = code_i;
    cmd.rep  = repeat_req_i;
    cmd.rcol = COL_W'(read_column_i);
    cmd.rrow = ROW_W'(read_row_i);
    if (code_i < CHAR_W'(KEY_NONE)) begin
      cmd.key = key_e'(code_i[3:0]);
    end else begin
      cmd.key = KEY_NONE;
    end
    unique case (code_i)
      CHR_BS:  cmd.chr = CH_BS;
      CHR_TAB: cmd.chr = CH_TAB;
      CHR_LF:  cmd.chr = CH_LF;
      CHR_CR:  cmd.chr = CH_CR;
      CHR_ESC: cmd.chr = CH_ESC;
      default: cmd.chr = CH_PUT;
    endcase
  end

  assign in_ready_o = en_i && (cnt_q != QCNT_W'(QDEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_cmd_o    = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        ent_q[wr_ptr_q] <= cmd;
        wr_ptr_q        <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

[rtl/core/tscb_back.sv]
module tscb_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [tscb_pkg::NC_W-1:0]    used_cols_i,
  input  logic [tscb_pkg::NR_W-1:0]    used_rows_i,
  input  logic                         q_valid_i,
  input  tscb_pkg::cmd_t               q_cmd_i,
  output logic                         q_pop_o,
  output logic                         init_done_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tscb_pkg::RCOL_FW-1:0] caret_column_o,
  output logic [tscb_pkg::RROW_FW-1:0] caret_row_o,
  output logic [tscb_pkg::CHAR_W-1:0]  cell_char_o
);
  import tscb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RESP,
    ST_RD_WAIT,
    ST_CHAR,
    ST_TAB,
    ST_DEL_RD,
    ST_DEL_WR
  } state_e;

  state_e             state_q, ret_q;
  logic               init_done_q;
  logic [COL_W-1:0]   col_q, dc_q;
  logic [ROW_W-1:0]   row_q;
  logic [REP_W-1:0]   rep_q;
  logic [CHAR_W-1:0]  code_q, cell_q;
  chr_e               chr_q;
  logic [ADDR_W-1:0]  sweep_q;
  logic               out_valid_q;
  logic [RCOL_FW-1:0] out_col_q;
  logic [RROW_FW-1:0] out_row_q;
  logic [CHAR_W-1:0]  out_cell_q;

  logic [COL_W-1:0]  sc, kc, pc_col, last_col;
  logic [ROW_W-1:0]  sr, kr, pc_row, nxt_row;
  logic [NC_W-1:0]   col_inc, dc_inc;
  logic [NR_W-1:0]   row_inc;
  logic              ram_we, ram_re, out_free;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;

  tscb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign last_col = COL_W'(used_cols_i - NC_W'(1));

  always_comb begin
    // caret pulled back inside the current size
    sc = ({1'b0, col_q} >= used_cols_i) ? last_col : col_q;
    sr = ({1'b0, row_q} >= used_rows_i) ? ROW_W'(used_rows_i - NR_W'(1)) : row_q;

    row_inc = {1'b0, row_q} + NR_W'(1);
    nxt_row = (row_inc >= used_rows_i) ? '0 : row_inc[ROW_W-1:0];
    col_inc = {1'b0, col_q} + NC_W'(1);
    if (col_inc >= used_cols_i) begin
      pc_col = '0;
      pc_row = nxt_row;
    end else begin
      pc_col = col_inc[COL_W-1:0];
      pc_row = row_q;
    end
    dc_inc = {1'b0, dc_q} + NC_W'(1);

    kc = sc;
    kr = sr;
    unique case (q_cmd_i.key)
      KEY_HOME:  kc = '0;
      KEY_END:   kc = last_col;
      KEY_PGUP:  kr = '0;
      KEY_PGDN:  kr = ROW_W'(used_rows_i - NR_W'(1));
      KEY_LEFT:  if (sc != '0) kc = sc - COL_W'(1);
      KEY_RIGHT: if ({1'b0, sc} + NC_W'(1) < used_cols_i) kc = sc + COL_W'(1);
      KEY_UP:    if (sr != '0) kr = sr - ROW_W'(1);
      KEY_DOWN:  if ({1'b0, sr} + NR_W'(1) < used_rows_i) kr = sr + ROW_W'(1);
      default:   ;
    endcase

    ram_we    = 1'b0;
    ram_waddr = cell_addr(col_q, row_q);
    ram_wdata = CHR_SPACE;
    ram_re    = 1'b0;
    ram_raddr = cell_addr(q_cmd_i.rcol, q_cmd_i.rrow);
    q_pop_o   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        q_pop_o = q_valid_i;
        ram_re  = q_valid_i && (q_cmd_i.kind == OP_READ);
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
      end
      ST_CHAR: begin
        if (rep_q != '0 && (chr_q == CH_TAB || chr_q == CH_PUT)) begin
          ram_we    = 1'b1;
          ram_wdata = (chr_q == CH_TAB) ? CHR_SPACE : code_q;
        end
      end
      ST_TAB: ram_we = 1'b1;
      ST_DEL_RD: begin
        if (dc_inc < used_cols_i) begin
          ram_re    = 1'b1;
          ram_raddr = cell_addr(dc_inc[COL_W-1:0], row_q);
        end else begin
          ram_we    = 1'b1;
          ram_waddr = cell_addr(last_col, row_q);
        end
      end
      ST_DEL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(dc_q, row_q);
        ram_wdata = ram_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ret_q       <= ST_IDLE;
      init_done_q <= 1'b0;
      sweep_q     <= '0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != ST_RESP) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            cell_q <= '0;
            unique case (q_cmd_i.kind)
              OP_KEY: begin
                col_q <= kc;
                row_q <= kr;
                if (q_cmd_i.key == KEY_DELETE) begin
                  dc_q    <= sc;
                  ret_q   <= ST_RESP;
                  state_q <= ST_DEL_RD;
                end else begin
                  state_q <= ST_RESP;
                end
              end
              OP_CHAR: begin
                col_q   <= sc;
                row_q   <= sr;
                rep_q   <= q_cmd_i.rep;
                code_q  <= q_cmd_i.code;
                chr_q   <= q_cmd_i.chr;
                state_q <= ST_CHAR;
              end
              OP_READ: begin
                col_q   <= sc;
                row_q   <= sr;
                state_q <= ST_RD_WAIT;
              end
              default: begin
                col_q   <= '0;
                row_q   <= '0;
                sweep_q <= '0;
                ret_q   <= ST_RESP;
                state_q <= ST_CLEAR;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          sweep_q <= sweep_q + ADDR_W'(1);
          if (sweep_q == ADDR_W'(DEPTH - 1)) begin
            init_done_q <= 1'b1;
            state_q     <= ret_q;
          end
        end
        ST_RD_WAIT: begin
          cell_q  <= ram_rdata;
          state_q <= ST_RESP;
        end
        ST_CHAR: begin
          if (rep_q == '0) begin
            state_q <= ST_RESP;
          end else begin
            rep_q <= rep_q - REP_W'(1);
            unique case (chr_q)
              CH_BS: begin
                if (col_q != '0) begin
                  col_q   <= col_q - COL_W'(1);
                  dc_q    <= col_q - COL_W'(1);
                  ret_q   <= ST_CHAR;
                  state_q <= ST_DEL_RD;
                end
              end
              CH_TAB: begin
                col_q <= pc_col;
                row_q <= pc_row;
                if (!on_tab_stop(pc_col)) state_q <= ST_TAB;
              end
              CH_LF: row_q <= nxt_row;
              CH_CR: begin
                col_q <= '0;
                row_q <= nxt_row;
              end
              CH_ESC: begin
                col_q   <= '0;
                row_q   <= '0;
                sweep_q <= '0;
                ret_q   <= ST_CHAR;
                state_q <= ST_CLEAR;
              end
              default: begin
                col_q <= pc_col;
                row_q <= pc_row;
              end
            endcase
          end
        end
        ST_TAB: begin
          col_q <= pc_col;
          row_q <= pc_row;
          if (on_tab_stop(pc_col)) state_q <= ST_CHAR;
        end
        ST_DEL_RD: begin
          // shift one cell per read/write pair, then blank the last column
          if (dc_inc < used_cols_i) begin
            state_q <= ST_DEL_WR;
          end else begin
            state_q <= ret_q;
          end
        end
        ST_DEL_WR: begin
          dc_q    <= dc_inc[COL_W-1:0];
          state_q <= ST_DEL_RD;
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_col_q   <= RCOL_FW'(col_q);
            out_row_q   <= RROW_FW'(row_q);
            out_cell_q  <= cell_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign init_done_o    = init_done_q;
  assign out_valid_o    = out_valid_q;
  assign caret_column_o = out_col_q;
  assign caret_row_o    = out_row_q;
  assign cell_char_o    = out_cell_q;

endmodule

[rtl/core/text_screen_buffer_caret_engine.sv]
// Caret keys pass through dispatch and the result register; cell reads add a registered store read.
// Character words step once per repeat; tab writes spaces up to the next tab stop.
// Delete/backspace: each shifted cell takes a read and a write, then the last column is blanked.
// Escape and reinit clear walk all 8192 store cells, one per cycle, on the single write port.
// After reset the store is swept to spaces before any input word is taken;
// config writes are taken at all times.
module text_screen_buffer_caret_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_index_i,
  input  logic [tscb_pkg::COLS_FW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tscb_pkg::OP_FW-1:0]   op_i,
  input  logic [tscb_pkg::CHAR_W-1:0]  code_i,
  input  logic [tscb_pkg::REP_W-1:0]   repeat_req_i,
  input  logic [tscb_pkg::RCOL_FW-1:0] read_column_i,
  input  logic [tscb_pkg::RROW_FW-1:0] read_row_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tscb_pkg::RCOL_FW-1:0] caret_column_o,
  output logic [tscb_pkg::RROW_FW-1:0] caret_row_o,
  output logic [tscb_pkg::CHAR_W-1:0]  cell_char_o
);
  import tscb_pkg::*;

  logic [COLS_FW-1:0] columns_q;
  logic [ROWS_FW-1:0] rows_q;
  logic [NC_W-1:0]    used_cols;
  logic [NR_W-1:0]    used_rows;
  logic               q_valid, q_pop, init_done;
  cmd_t               q_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= COLS_FW'(80);
      rows_q    <= ROWS_FW'(25);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_COLUMNS: columns_q <= cfg_data_i;
        CFG_ROWS:    rows_q    <= cfg_data_i[ROWS_FW-1:0];
        default:     ;
      endcase
    end
  end

  // size registers clamped into 1..max
  always_comb begin
    if (columns_q == '0) begin
      used_cols = NC_W'(1);
    end else if (int'(columns_q) > MAX_COLUMNS) begin
      used_cols = NC_W'(MAX_COLUMNS);
    end else begin
      used_cols = NC_W'(columns_q);
    end
    if (rows_q == '0) begin
      used_rows = NR_W'(1);
    end else if (int'(rows_q) > MAX_ROWS) begin
      used_rows = NR_W'(MAX_ROWS);
    end else begin
      used_rows = NR_W'(rows_q);
    end
  end

  tscb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (init_done),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .code_i        (code_i),
    .repeat_req_i  (repeat_req_i),
    .read_column_i (read_column_i),
    .read_row_i    (read_row_i),
    .q_valid_o     (q_valid),
    .q_cmd_o       (q_cmd),
    .q_pop_i       (q_pop)
  );

  tscb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .used_cols_i    (used_cols),
    .used_rows_i    (used_rows),
    .q_valid_i      (q_valid),
    .q_cmd_i        (q_cmd),
    .q_pop_o        (q_pop),
    .init_done_o    (init_done),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .caret_column_o (caret_column_o),
    .caret_row_o    (caret_row_o),
    .cell_char_o    (cell_char_o)
  );

endmodule
